// ===== hdl/dpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

  // table size and derived widths
  localparam int MAX_REGIONS = 8;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int COUNT_W     = $clog2(MAX_REGIONS + 1);

  localparam logic [63:0] PAGE_MASK  = 64'hFFF;
  localparam logic [12:0] PAGE_BYTES = 13'd4096;

  // operation codes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;
  localparam logic [1:0] OP_FAULT  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOT_HAND = 3'd3;
  localparam logic [2:0] ST_HANDLED  = 3'd4;

  // fault error code bits
  localparam int ERR_PROT_BIT = 0;
  localparam int ERR_RSVD_BIT = 3;

  typedef struct packed {
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [63:0] file_base;
    logic [63:0] file_end;
  } dpr_region_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] load_offset;
    logic [12:0] load_bytes;
  } dpr_match_t;

  // low 3 bits of a table index, zero extended when the index is narrower
  function automatic logic [2:0] to_region_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] wide;
    wide = {3'b000, idx};
    return wide[2:0];
  endfunction

  function automatic logic [COUNT_W-1:0] idx_to_count(input logic [IDX_W-1:0] idx);
    logic [IDX_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, idx};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dpr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        seg_is_load;
  logic [63:0] seg_vaddr;
  logic [63:0] seg_memsz;
  logic [63:0] seg_filesz;
  logic [63:0] seg_file_offset;
  logic [63:0] fault_addr;
  logic [15:0] fault_error;

  modport source (
    output valid, operation, seg_is_load, seg_vaddr, seg_memsz, seg_filesz,
           seg_file_offset, fault_addr, fault_error,
    input  ready
  );

  modport sink (
    input  valid, operation, seg_is_load, seg_vaddr, seg_memsz, seg_filesz,
           seg_file_offset, fault_addr, fault_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/dpr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  region_index;
  logic [63:0] page_addr;
  logic [31:0] load_offset;
  logic [12:0] load_bytes;

  modport source (
    output valid, status, region_index, page_addr, load_offset, load_bytes,
    input  ready
  );

  modport sink (
    input  valid, status, region_index, page_addr, load_offset, load_bytes,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/dpr_region_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpr_region_mem (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [dpr_pkg::IDX_W-1:0]   wr_addr,
  input  wire dpr_pkg::dpr_region_t        wr_data,
  input  wire logic [dpr_pkg::IDX_W-1:0]   rd_addr,
  output dpr_pkg::dpr_region_t             rd_data
);

  dpr_pkg::dpr_region_t mem [dpr_pkg::MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/dpr_match_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpr_match_unit (
  input  wire logic [63:0]          page,
  input  wire dpr_pkg::dpr_region_t region,
  output dpr_pkg::dpr_match_t       result
);

  logic        in_file;
  logic [63:0] rest;
  logic [31:0] delta;

  assign in_file = page < region.file_end;
  assign rest    = region.file_end - page;
  assign delta   = page[31:0] - region.start_addr[31:0];

  always_comb begin
    // an empty region (end at or below start) can never satisfy both compares
    result.hit         = (page >= region.start_addr) && (page < region.end_addr);
    result.load_offset = '0;
    result.load_bytes  = '0;
    if (in_file) begin
      result.load_offset = region.file_base[31:0] + delta;
      if (rest < 64'(dpr_pkg::PAGE_BYTES)) begin
        result.load_bytes = rest[12:0];
      end else begin
        result.load_bytes = dpr_pkg::PAGE_BYTES;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/demand_page_region_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// path from accept to result: begin, commit, skipped or full add, refused fault or
//   empty table go straight to S_OUT; a stored add passes S_ADD; a fault passes S_READ,
//   then S_SCAN reads one region per cycle from the table memory into one shared
//   compare unit, and goes to S_CALC on a hit or to S_OUT after the last region
// one item at a time; ready returns in the same cycle as the result is registered
// reset (rst, synchronous, active high) empties the table and detaches the image

module demand_page_region_lookup (
  input wire logic clk,
  input wire logic rst,
  dpr_in_if.sink   req,
  dpr_out_if.source rsp
);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_READ = 6'b000100,
    S_SCAN = 6'b001000,
    S_CALC = 6'b010000,
    S_OUT  = 6'b100000
  } dpr_state_t;

  dpr_state_t state;

  // architectural state
  logic [dpr_pkg::COUNT_W-1:0] region_count;
  logic                        image_attached;

  // captured item
  logic [63:0] seg_vaddr;
  logic [63:0] seg_memsz;
  logic [63:0] seg_filesz;
  logic [63:0] seg_file_offset;
  logic [63:0] fault_page;

  // scan index
  logic [dpr_pkg::IDX_W-1:0] idx;
  logic [dpr_pkg::IDX_W-1:0] idx_next;
  logic                      scan_last;

  // pending result, moved to the output register in S_OUT
  logic [2:0]  res_status;
  logic [2:0]  res_index;
  logic [63:0] res_page;
  logic [31:0] res_offset;
  logic [12:0] res_bytes;

  // output register
  logic        out_valid;
  logic [2:0]  out_status;
  logic [2:0]  out_index;
  logic [63:0] out_page;
  logic [31:0] out_offset;
  logic [12:0] out_bytes;

  // table and compare unit wiring
  logic                      wr_en;
  dpr_pkg::dpr_region_t      wr_data;
  logic [dpr_pkg::IDX_W-1:0] rd_addr;
  dpr_pkg::dpr_region_t      rd_data;
  dpr_pkg::dpr_match_t       match;

  logic accept;
  logic table_full;
  logic out_free;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign table_full = region_count >= dpr_pkg::COUNT_W'(dpr_pkg::MAX_REGIONS);
  assign out_free   = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.region_index = out_index;
  assign rsp.page_addr    = out_page;
  assign rsp.load_offset  = out_offset;
  assign rsp.load_bytes   = out_bytes;

  // region built from the captured segment, written in S_ADD
  assign wr_en              = (state == S_ADD);
  assign wr_data.start_addr = seg_vaddr & ~dpr_pkg::PAGE_MASK;
  assign wr_data.end_addr   = (seg_vaddr + seg_memsz + dpr_pkg::PAGE_MASK) & ~dpr_pkg::PAGE_MASK;
  assign wr_data.file_base  = seg_file_offset - (seg_vaddr & dpr_pkg::PAGE_MASK);
  assign wr_data.file_end   = seg_vaddr + seg_filesz;

  assign idx_next  = idx + dpr_pkg::IDX_W'(1);
  assign scan_last = (dpr_pkg::idx_to_count(idx) + dpr_pkg::COUNT_W'(1)) == region_count;

  // keep the matched entry on the read port for S_CALC, otherwise fetch the next one
  always_comb begin
    if (state == S_SCAN && !match.hit) begin
      rd_addr = idx_next;
    end else begin
      rd_addr = idx;
    end
  end

  dpr_region_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (region_count[dpr_pkg::IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dpr_match_unit u_match (
    .page   (fault_page),
    .region (rd_data),
    .result (match)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      region_count   <= '0;
      image_attached <= 1'b0;
      idx            <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.operation)
              dpr_pkg::OP_BEGIN: begin
                region_count   <= '0;
                image_attached <= 1'b0;
                state          <= S_OUT;
              end
              dpr_pkg::OP_ADD: begin
                if (!req.seg_is_load || req.seg_memsz == 64'd0 || table_full) begin
                  state <= S_OUT;
                end else begin
                  state <= S_ADD;
                end
              end
              dpr_pkg::OP_COMMIT: begin
                image_attached <= 1'b1;
                state          <= S_OUT;
              end
              dpr_pkg::OP_FAULT: begin
                idx <= '0;
                if (!image_attached || req.fault_error[dpr_pkg::ERR_PROT_BIT] ||
                    req.fault_error[dpr_pkg::ERR_RSVD_BIT] || region_count == '0) begin
                  state <= S_OUT;
                end else begin
                  state <= S_READ;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_ADD: begin
          region_count <= region_count + dpr_pkg::COUNT_W'(1);
          state        <= S_OUT;
        end
        S_READ: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (match.hit) begin
            state <= S_CALC;
          end else if (scan_last) begin
            state <= S_OUT;
          end else begin
            idx <= idx_next;
          end
        end
        S_CALC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_vaddr       <= req.seg_vaddr;
      seg_memsz       <= req.seg_memsz;
      seg_filesz      <= req.seg_filesz;
      seg_file_offset <= req.seg_file_offset;
      fault_page      <= req.fault_addr & ~dpr_pkg::PAGE_MASK;
      res_index       <= '0;
      res_page        <= '0;
      res_offset      <= '0;
      res_bytes       <= '0;
      case (req.operation)
        dpr_pkg::OP_ADD: begin
          if (!req.seg_is_load || req.seg_memsz == 64'd0) begin
            res_status <= dpr_pkg::ST_SKIPPED;
          end else if (table_full) begin
            res_status <= dpr_pkg::ST_FULL;
          end else begin
            res_status <= dpr_pkg::ST_DONE;
          end
        end
        dpr_pkg::OP_FAULT: res_status <= dpr_pkg::ST_NOT_HAND;
        default:           res_status <= dpr_pkg::ST_DONE;
      endcase
    end else if (state == S_ADD) begin
      res_index <= dpr_pkg::to_region_index(region_count[dpr_pkg::IDX_W-1:0]);
    end else if (state == S_CALC) begin
      res_status <= dpr_pkg::ST_HANDLED;
      res_index  <= dpr_pkg::to_region_index(idx);
      res_page   <= fault_page;
      res_offset <= match.load_offset;
      res_bytes  <= match.load_bytes;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_page   <= res_page;
      out_offset <= res_offset;
      out_bytes  <= res_bytes;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dpr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  status,
  input wire logic [63:0] page_addr,
  input wire logic [31:0] load_offset,
  input wire logic [12:0] load_bytes
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(page_addr))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready high in the cycle after an accept");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= dpr_pkg::ST_HANDLED)
    else $error("status code out of range");

  // only a handled fault carries page and load fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != dpr_pkg::ST_HANDLED |->
      page_addr == 64'd0 && load_offset == 32'd0 && load_bytes == 13'd0)
    else $error("nonzero fields on a result other than a handled fault");

  a_page: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == dpr_pkg::ST_HANDLED |->
      page_addr[11:0] == 12'd0 && load_bytes <= dpr_pkg::PAGE_BYTES)
    else $error("handled fault with unaligned page or oversize load");

endmodule

bind demand_page_region_lookup dpr_checker u_dpr_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .page_addr   (rsp.page_addr),
  .load_offset (rsp.load_offset),
  .load_bytes  (rsp.load_bytes)
);

`default_nettype wire

// ===== tb/demand_page_region_lookup_test.sv =====
`timescale 1ns / 1ps

module demand_page_region_lookup_test;
  import dpr_pkg::*;

  // cycles with no item moving on either side before the run is called hung
  localparam int IDLE_LIMIT = 2000;
  // cycles to keep watching the output once nothing is expected any more
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1000;

  // one request item as the block sees it
  typedef struct packed {
    logic [1:0]  op;
    logic        is_load;
    logic [63:0] vaddr;
    logic [63:0] memsz;
    logic [63:0] filesz;
    logic [63:0] foff;
    logic [63:0] faddr;
    logic [15:0] ferr;
  } seg_req_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  region_index;
    logic [63:0] page_addr;
    logic [31:0] load_offset;
    logic [12:0] load_bytes;
  } lookup_rsp_t;

  // a queued request with the idle cycles that precede it, and whether the
  // sender holds it back until every outstanding result has come home
  typedef struct {
    seg_req_t    req;
    int unsigned lead;
    bit          hold;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpr_in_if  req_if ();
  dpr_out_if rsp_if ();

  demand_page_region_lookup uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tb-side copies of everything driven into the block, known from time zero
  logic     drv_valid  = 1'b0;
  seg_req_t drv_item   = '0;
  logic     sink_ready = 1'b0;

  assign req_if.valid           = drv_valid;
  assign req_if.operation       = drv_item.op;
  assign req_if.seg_is_load     = drv_item.is_load;
  assign req_if.seg_vaddr       = drv_item.vaddr;
  assign req_if.seg_memsz       = drv_item.memsz;
  assign req_if.seg_filesz      = drv_item.filesz;
  assign req_if.seg_file_offset = drv_item.foff;
  assign req_if.fault_addr      = drv_item.faddr;
  assign req_if.fault_error     = drv_item.ferr;
  assign rsp_if.ready           = sink_ready;

  pending_req_t req_backlog[$];
  lookup_rsp_t  expected_rsp[$];
  int unsigned  errors = 0;

  // shadow of the region table, kept in step with accepted requests
  logic [63:0] tbl_start [MAX_REGIONS];
  logic [63:0] tbl_end   [MAX_REGIONS];
  logic [63:0] tbl_fbase [MAX_REGIONS];
  logic [63:0] tbl_fend  [MAX_REGIONS];
  int          tbl_count = 0;
  bit          attached  = 1'b0;

  // works out the result of one request and updates the shadow table
  function automatic lookup_rsp_t predict_lookup(input seg_req_t r);
    lookup_rsp_t res;
    logic [63:0] page;
    logic [63:0] rest;
    bit          found;
    res   = '0;
    found = 1'b0;
    case (r.op)
      OP_BEGIN: begin
        tbl_count = 0;
        attached  = 1'b0;
      end
      OP_COMMIT: begin
        attached = 1'b1;
      end
      OP_ADD: begin
        // a skip wins over a full table
        if (!r.is_load || r.memsz == 64'd0) begin
          res.status = ST_SKIPPED;
        end else if (tbl_count >= MAX_REGIONS) begin
          res.status = ST_FULL;
        end else begin
          tbl_start[tbl_count] = r.vaddr & ~PAGE_MASK;
          tbl_end[tbl_count]   = (r.vaddr + r.memsz + PAGE_MASK) & ~PAGE_MASK;
          tbl_fbase[tbl_count] = r.foff - (r.vaddr & PAGE_MASK);
          tbl_fend[tbl_count]  = r.vaddr + r.filesz;
          res.status       = ST_DONE;
          res.region_index = 3'(tbl_count);
          tbl_count++;
        end
      end
      default: begin
        res.status = ST_NOT_HAND;
        page = r.faddr & ~PAGE_MASK;
        // detached image, protection fault or reserved bit: left unhandled
        if (attached && !r.ferr[ERR_PROT_BIT] && !r.ferr[ERR_RSVD_BIT]) begin
          // first region holding the page wins; a wrapped region holds nothing
          for (int k = 0; k < tbl_count && !found; k++) begin
            if (page >= tbl_start[k] && page < tbl_end[k]) begin
              found            = 1'b1;
              res.status       = ST_HANDLED;
              res.region_index = 3'(k);
              res.page_addr    = page;
              // page past the file image is all zero, nothing to read
              if (page < tbl_fend[k]) begin
                rest            = tbl_fend[k] - page;
                res.load_offset = 32'(tbl_fbase[k] + (page - tbl_start[k]));
                res.load_bytes  = (rest < 64'd4096) ? 13'(rest) : PAGE_BYTES;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  int unsigned lead_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      lead_left <= 0;
    end else if (drv_valid && req_if.ready) begin
      expected_rsp.push_back(predict_lookup(drv_item));
      // back-to-back when the next item asks for no gap and no drain
      if (req_backlog.size() != 0 && req_backlog[0].lead == 0 && !req_backlog[0].hold) begin
        drv_item <= req_backlog[0].req;
        req_backlog.pop_front();
      end else begin
        drv_valid <= 1'b0;
        if (req_backlog.size() != 0) lead_left <= req_backlog[0].lead;
      end
    end else if (!drv_valid && req_backlog.size() != 0) begin
      if (lead_left != 0) begin
        lead_left <= lead_left - 1;
      end else if (!req_backlog[0].hold || expected_rsp.size() == 0) begin
        drv_item  <= req_backlog[0].req;
        drv_valid <= 1'b1;
        req_backlog.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes results with random back-pressure, checks against the
  // oldest prediction
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned sink_calm  = 0;
  int unsigned stall_draw;
  lookup_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
      sink_calm  <= 0;
    end else if (rsp_if.valid && sink_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time,
                 {rsp_if.status, rsp_if.region_index, rsp_if.page_addr,
                  rsp_if.load_offset, rsp_if.load_bytes});
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        compare_field("status", 64'(want.status), 64'(rsp_if.status));
        compare_field("region_index", 64'(want.region_index), 64'(rsp_if.region_index));
        compare_field("page_addr", want.page_addr, rsp_if.page_addr);
        compare_field("load_offset", 64'(want.load_offset), 64'(rsp_if.load_offset));
        compare_field("load_bytes", 64'(want.load_bytes), 64'(rsp_if.load_bytes));
      end
      // stall draw for the next item, with occasional runs of no stall
      if (sink_calm != 0) begin
        sink_calm <= sink_calm - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        sink_calm <= $urandom_range(10, 60);
      end else begin
        stall_draw = $urandom_range(0, 3);
        if (stall_draw != 0) begin
          sink_ready <= 1'b0;
          stall_left <= stall_draw;
        end
      end
    end else if (!sink_ready) begin
      if (stall_left <= 1) sink_ready <= 1'b1;
      if (stall_left != 0) stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: nothing moving for too long means the block is stuck
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (drv_valid && req_if.ready) || (rsp_if.valid && sink_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("demand_page_region_lookup_test: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int unsigned src_calm = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // queues one item with a random lead gap; runs of zero gap now and then
  task automatic push_req(input logic [1:0] op, input logic is_load,
                          input logic [63:0] vaddr, input logic [63:0] memsz,
                          input logic [63:0] filesz, input logic [63:0] foff,
                          input logic [63:0] faddr, input logic [15:0] ferr,
                          input bit hold);
    pending_req_t p;
    p.req  = '{op, is_load, vaddr, memsz, filesz, foff, faddr, ferr};
    p.hold = hold;
    if (src_calm != 0) begin
      src_calm--;
      p.lead = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      src_calm = $urandom_range(10, 60);
      p.lead   = 0;
    end else begin
      p.lead = $urandom_range(0, 3);
    end
    req_backlog.push_back(p);
  endtask

  task automatic push_op(input logic [1:0] op);
    push_req(op, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 1'b0);
  endtask

  task automatic push_add(input logic is_load, input logic [63:0] vaddr,
                          input logic [63:0] memsz, input logic [63:0] filesz,
                          input logic [63:0] foff);
    push_req(OP_ADD, is_load, vaddr, memsz, filesz, foff, 64'd0, 16'd0, 1'b0);
  endtask

  task automatic push_fault(input logic [63:0] faddr, input logic [15:0] ferr,
                            input bit hold);
    push_req(OP_FAULT, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, faddr, ferr, hold);
  endtask

  // one image: begin, a run of segments, usually a commit, then faults that
  // mostly land inside the segments just added
  task automatic push_image();
    logic [63:0] seg_v [16];
    logic [63:0] seg_m [16];
    int          n_seg;
    int          n_rec;
    int          pick;
    int unsigned r;
    logic        is_load;
    logic [63:0] vaddr;
    logic [63:0] memsz;
    logic [63:0] filesz;
    logic [63:0] foff;
    logic [63:0] faddr;
    logic [15:0] ferr;
    n_rec = 0;
    push_op(OP_BEGIN);
    n_seg = $urandom_range(1, 10);
    for (int s = 0; s < n_seg; s++) begin
      is_load = ($urandom_range(0, 9) != 0);
      vaddr   = $urandom_range(0, 1) ? 64'($urandom_range(0, 32'h00FF_FFFF)) : rand64();
      r = $urandom_range(0, 19);
      if (r == 0) memsz = 64'd0;
      else if (r == 1) memsz = rand64();
      else memsz = 64'($urandom_range(1, 32'h0001_0000));
      r = $urandom_range(0, 9);
      if (r < 6) filesz = memsz >> $urandom_range(0, 4);
      else if (r < 8) filesz = 64'd0;
      else filesz = rand64();
      foff = $urandom_range(0, 1) ? 64'($urandom) : rand64();
      push_add(is_load, vaddr, memsz, filesz, foff);
      if (is_load && memsz != 64'd0 && n_rec < 16) begin
        seg_v[n_rec] = vaddr;
        seg_m[n_rec] = memsz;
        n_rec++;
      end
    end
    // an image is sometimes left detached so its faults go unhandled
    if ($urandom_range(0, 7) != 0) push_op(OP_COMMIT);
    for (int f = $urandom_range(4, 24); f > 0; f--) begin
      r = $urandom_range(0, 9);
      if (n_rec != 0 && r < 8) begin
        pick  = $urandom_range(0, n_rec - 1);
        faddr = seg_v[pick] + (rand64() % seg_m[pick]);
      end else if (n_rec != 0 && r == 8) begin
        pick  = $urandom_range(0, n_rec - 1);
        faddr = seg_v[pick] + seg_m[pick] + 64'($urandom_range(0, 32'h1FFF));
      end else begin
        faddr = rand64();
      end
      ferr = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        ferr[ERR_PROT_BIT] = 1'b0;
        ferr[ERR_RSVD_BIT] = 1'b0;
      end
      push_fault(faddr, ferr, ($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    // directed: fault with no image attached yet
    push_fault(64'h1000, 16'h0000, 1'b0);
    push_op(OP_BEGIN);
    // not loadable, then zero memory size: both skipped
    push_add(1'b0, 64'h1000, 64'h1000, 64'h1000, 64'h0);
    push_add(1'b1, 64'h1000, 64'h0, 64'h1000, 64'h0);
    // region 0: unaligned start, file part ends mid page
    push_add(1'b1, 64'h1234, 64'h3000, 64'h1800, 64'h5234);
    // region 1: end wraps past the top of the address space, holds nothing
    push_add(1'b1, 64'hFFFF_FFFF_FFFF_F800, 64'h1000, 64'h800, 64'h0);
    // region 2: no file part at all, pages come back all zero
    push_add(1'b1, 64'h10000, 64'h2000, 64'h0, '1);
    // region 3: every field at its maximum
    push_add(1'b1, '1, '1, '1, '1);
    // region 4: file offset above 32 bits is truncated on output
    push_add(1'b1, 64'h1_0000_0000, 64'h1000, 64'h1000, 64'h1_2345_6000);
    // regions 5 to 7 overlap region 0, which must still win
    for (int k = 5; k < MAX_REGIONS; k++)
      push_add(1'b1, 64'h1000, 64'h1000, 64'h1000, 64'h0);
    // table full, and a non-loadable segment on a full table is a skip
    push_add(1'b1, 64'h2000_0000, 64'h1000, 64'h1000, 64'h0);
    push_add(1'b0, 64'h2000_0000, 64'h1000, 64'h1000, 64'h0);
    push_req(OP_COMMIT, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 16'd0, 1'b1);
    // first page of region 0 loads a whole page
    push_fault(64'h1FFF, 16'h0000, 1'b0);
    // partial page; error bits other than protection and reserved are ignored
    push_fault(64'h2ABC, 16'hFFF6, 1'b0);
    // past the file part of region 0
    push_fault(64'h3000, 16'h0000, 1'b0);
    push_fault(64'h10010, 16'h0000, 1'b0);
    push_fault(64'h1_0000_0123, 16'h0000, 1'b0);
    // protection bit and reserved bit each refuse the fault
    push_fault(64'h1000, 16'h0001, 1'b0);
    push_fault(64'h1000, 16'h0008, 1'b0);
    // top page: only wrapped regions near it, so nothing holds it
    push_fault('1, 16'h0000, 1'b0);
    push_fault(64'h5000, 16'h0000, 1'b1);
    // begin detaches again
    push_op(OP_BEGIN);
    push_fault(64'h1000, 16'h0000, 1'b0);

    // random: mostly whole images, some loose items with any operation
    while (req_backlog.size() < RANDOM_ITEMS + 26) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(2'($urandom_range(0, 3)), 1'($urandom), rand64(), rand64(), rand64(),
                 rand64(), rand64(), 16'($urandom), 1'b0);
      end else begin
        push_image();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (drv_valid || req_backlog.size() != 0 || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("demand_page_region_lookup_test: clean");
    end else begin
      $display("demand_page_region_lookup_test: errors");
    end
    $finish;
  end

endmodule
